>>> design/wipd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wipd_pkg;

	// vector length at which the component index stops counting
	localparam int MAX_DIMENSION = 1024;
	localparam int IDX_W = $clog2(MAX_DIMENSION + 1);

	// configuration port
	localparam int WCOUNT_W = 11;
	localparam int WEIGHT_W = 24;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 1'b1;
	localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = '0;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 24'd65536;

	// operation codes
	localparam logic OP_DOT = 1'b0;
	localparam logic OP_DIST = 1'b1;

	// datapath widths
	localparam int A_W = 32;
	localparam int FRAC_W = 16;
	localparam int OPND_W = A_W + 2;
	localparam int PROD_W = 2 * OPND_W;
	localparam int TERM_W = 49;
	localparam int WSPLIT = 24;
	localparam int THI_W = TERM_W - WSPLIT;
	localparam int PHI_W = THI_W + WEIGHT_W + 1;
	localparam int PLO_W = WSPLIT + WEIGHT_W;
	localparam int WSUM_W = PHI_W + WSPLIT + 1;
	localparam int WTERM_W = 58;
	localparam int ACC_W = 48;
	localparam int SUM_W = WTERM_W + 1;

	// term queue between front and back
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PIPE_STAGES = 4;
	localparam int INFL_W = $clog2(PIPE_STAGES + 1);

	// square root unit, one root bit per cycle
	localparam int ROOT_W = ACC_W / 2;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int REM_W = ROOT_W + 3;
	localparam int SCNT_W = $clog2(SQRT_STEPS);

	typedef struct packed {
		logic signed [WTERM_W-1:0] term;
		logic op;
		logic last;
	} wipd_entry_t;

endpackage
`default_nettype wire

>>> design/weighted_inner_product_distance_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming weighted inner product / weighted euclidean distance. One request carries one
// pair of Q16.16 components; the block takes one request per cycle, limited only by the
// 8-entry term queue. The front runs a four-stage pipeline (operand select, 34x34 multiply,
// split 25x24 and 24x24 weight multiplies, recombine) and the back adds one term per cycle,
// unless a root is in progress or an inner-product result waits for the output, into the
// saturating Q32.16 accumulator. A distance result goes through a one-bit-per-cycle square
// root unit; the back takes no new term until the root reaches the output, so a following
// vector streams on until the queue fills. The user must see that the weighted_count and
// weight registers are written only while the block is idle; the block does not enforce it.
module weighted_inner_product_distance_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [wipd_pkg::A_W-1:0]     a_value,
	input  logic signed [wipd_pkg::A_W-1:0]     b_value,
	input  logic                                last_component,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [wipd_pkg::ACC_W-1:0]   result_value,
	output logic                                overflow,
	input  logic                                cfg_write,
	input  logic [wipd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wipd_pkg::CFG_W-1:0]          cfg_data
);
	import wipd_pkg::*;

	logic push;
	wipd_entry_t push_entry;
	logic pop;
	logic head_valid;
	wipd_entry_t head_entry;
	logic [QCNT_W-1:0] queue_count;

	wipd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.a_value        (a_value),
		.b_value        (b_value),
		.last_component (last_component),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.queue_count    (queue_count),
		.push           (push),
		.push_entry     (push_entry)
	);

	wipd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.count      (queue_count)
	);

	wipd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.overflow     (overflow)
	);

endmodule
`default_nettype wire

>>> design/wipd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module wipd_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               op,
	input  logic signed [wipd_pkg::A_W-1:0]    a_value,
	input  logic signed [wipd_pkg::A_W-1:0]    b_value,
	input  logic                               last_component,
	input  logic                               cfg_write,
	input  logic [wipd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wipd_pkg::CFG_W-1:0]         cfg_data,
	input  logic [wipd_pkg::QCNT_W-1:0]        queue_count,
	output logic                               push,
	output wipd_pkg::wipd_entry_t              push_entry
);
	import wipd_pkg::*;

	logic [WCOUNT_W-1:0] wcount_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [IDX_W-1:0] idx_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic op_s1, op_s2, op_s3, op_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic weighted_s1, weighted_s2, weighted_s3;
	logic signed [OPND_W-1:0] x_s1, y_s1;
	logic [TERM_W-1:0] term_s2, term_s3;
	logic signed [PHI_W-1:0] phi_s3;
	logic [PLO_W-1:0] plo_s3;
	logic signed [WTERM_W-1:0] term_s4;

	logic accept;
	logic [INFL_W-1:0] inflight;
	logic [QCNT_W:0] demand;
	logic signed [A_W:0] diff;
	logic [A_W:0] absd;
	logic signed [PROD_W-1:0] prod;
	logic signed [THI_W-1:0] thi;
	logic signed [THI_W:0] wsig;
	logic signed [PHI_W-1:0] phi;
	logic [PLO_W-1:0] plo;
	logic [WSUM_W-1:0] wsum;

	// credit check: every item in the pipe already owns a queue slot
	assign inflight = INFL_W'(valid_s1) + INFL_W'(valid_s2) + INFL_W'(valid_s3)
		+ INFL_W'(valid_s4);
	assign demand = {1'b0, queue_count} + (QCNT_W + 1)'(inflight);
	assign in_stall = demand >= (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept = in_valid && !in_stall;

	assign diff = {a_value[A_W-1], a_value} - {b_value[A_W-1], b_value};
	assign absd = diff[A_W] ? (~diff + 1'b1) : diff;

	assign prod = x_s1 * y_s1;

	assign thi = term_s2[TERM_W-1:WSPLIT];
	assign wsig = {1'b0, weight_q};
	assign phi = thi * wsig;
	assign plo = term_s2[WSPLIT-1:0] * weight_q;

	assign wsum = {phi_s3[PHI_W-1], phi_s3, {WSPLIT{1'b0}}}
		+ {{(WSUM_W - PLO_W){1'b0}}, plo_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q <= WCOUNT_RESET;
			weight_q <= WEIGHT_RESET;
			idx_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_WEIGHTED_COUNT: wcount_q <= cfg_data[WCOUNT_W-1:0];
					CFG_WEIGHT:         weight_q <= cfg_data[WEIGHT_W-1:0];
					default:            ;
				endcase
			end
			if (accept) begin
				if (last_component) begin
					idx_q <= '0;
				end else if (idx_q < IDX_W'(MAX_DIMENSION)) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= op;
		last_s1 <= last_component;
		weighted_s1 <= {{(WCOUNT_W > IDX_W ? WCOUNT_W - IDX_W : 0){1'b0}}, idx_q}
			< wcount_q;
		if (op == OP_DOT) begin
			x_s1 <= {{(OPND_W - A_W){a_value[A_W-1]}}, a_value};
			y_s1 <= {{(OPND_W - A_W){b_value[A_W-1]}}, b_value};
		end else begin
			x_s1 <= {{(OPND_W - A_W - 1){1'b0}}, absd};
			y_s1 <= {{(OPND_W - A_W - 1){1'b0}}, absd};
		end

		// floor shift of the exact product down to the accumulator scale
		op_s2 <= op_s1;
		last_s2 <= last_s1;
		weighted_s2 <= weighted_s1;
		term_s2 <= prod[FRAC_W+TERM_W-1:FRAC_W];

		op_s3 <= op_s2;
		last_s3 <= last_s2;
		weighted_s3 <= weighted_s2;
		term_s3 <= term_s2;
		phi_s3 <= phi;
		plo_s3 <= plo;

		op_s4 <= op_s3;
		last_s4 <= last_s3;
		if (weighted_s3) begin
			term_s4 <= wsum[FRAC_W+WTERM_W-1:FRAC_W];
		end else begin
			term_s4 <= {{(WTERM_W - TERM_W){term_s3[TERM_W-1]}}, term_s3};
		end
	end

	assign push = valid_s4;
	assign push_entry = {term_s4, op_s4, last_s4};

endmodule
`default_nettype wire

>>> design/wipd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module wipd_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  wipd_pkg::wipd_entry_t           push_entry,
	input  logic                            pop,
	output logic                            head_valid,
	output wipd_pkg::wipd_entry_t           head_entry,
	output logic [wipd_pkg::QCNT_W-1:0]     count
);
	import wipd_pkg::*;

	wipd_entry_t slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head_valid = count_q != '0;
	assign head_entry = slot_q[rd_ptr_q];
	assign count = count_q;

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == QCNT_W'(QUEUE_DEPTH) |-> !push)
		else $error("term queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> !pop)
		else $error("term queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("term queue count lost a request");

endmodule
`default_nettype wire

>>> design/wipd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module wipd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  wipd_pkg::wipd_entry_t               head_entry,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [wipd_pkg::ACC_W-1:0]   result_value,
	output logic                                overflow
);
	import wipd_pkg::*;

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_SQRT = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic signed [ACC_W-1:0] acc_q;
	logic sat_q;
	logic out_valid_q;
	logic [SCNT_W-1:0] cnt_q;

	logic [ACC_W-1:0] result_q;
	logic ovf_q;
	logic [ACC_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic sqrt_ovf_q;

	logic out_free;
	logic [SUM_W-1:0] sum_full;
	logic clamp_hi, clamp_lo;
	logic [ACC_W-1:0] sum_c;
	logic sat_next;
	logic [REM_W-1:0] rem_shift, trial, rem_next;
	logic ge;
	logic [ROOT_W-1:0] root_next;

	assign out_free = !out_valid_q || !out_stall;

	assign sum_full = {{(SUM_W - ACC_W){acc_q[ACC_W-1]}}, acc_q}
		+ {head_entry.term[WTERM_W-1], head_entry.term};

	// the sum fits the accumulator when all bits above its sign agree
	assign clamp_hi = !sum_full[SUM_W-1] && (|sum_full[SUM_W-2:ACC_W-1]);
	assign clamp_lo = sum_full[SUM_W-1] && !(&sum_full[SUM_W-2:ACC_W-1]);
	always_comb begin
		if (clamp_hi) begin
			sum_c = {1'b0, {(ACC_W - 1){1'b1}}};
		end else if (clamp_lo) begin
			sum_c = {1'b1, {(ACC_W - 1){1'b0}}};
		end else begin
			sum_c = sum_full[ACC_W-1:0];
		end
	end
	assign sat_next = sat_q || clamp_hi || clamp_lo;

	// a distance result waits for the root, so it does not need the output slot yet
	always_comb begin
		pop = 1'b0;
		if (state_q == ST_RUN && head_valid) begin
			pop = !head_entry.last || head_entry.op == OP_DIST || out_free;
		end
	end

	// restoring square root, two radicand bits per step
	assign rem_shift = {rem_q[REM_W-3:0], rad_q[ACC_W-1:ACC_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge = rem_shift >= trial;
	assign rem_next = ge ? rem_shift - trial : rem_shift;
	assign root_next = {root_q[ROOT_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			acc_q <= '0;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (pop) begin
						if (head_entry.last) begin
							acc_q <= '0;
							sat_q <= 1'b0;
							if (head_entry.op == OP_DIST) begin
								state_q <= ST_SQRT;
								cnt_q <= '0;
							end else begin
								out_valid_q <= 1'b1;
							end
						end else begin
							acc_q <= sum_c;
							sat_q <= sat_next;
						end
					end
				end
				ST_SQRT: begin
					if (cnt_q == SCNT_W'(SQRT_STEPS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && pop && head_entry.last) begin
			if (head_entry.op == OP_DIST) begin
				rad_q <= sum_c[ACC_W-1] ? '0 : sum_c;
				rem_q <= '0;
				root_q <= '0;
				sqrt_ovf_q <= sat_next;
			end else begin
				result_q <= sum_c;
				ovf_q <= sat_next;
			end
		end
		if (state_q == ST_SQRT) begin
			rad_q <= {rad_q[ACC_W-3:0], 2'b00};
			rem_q <= rem_next;
			root_q <= root_next;
		end
		if (state_q == ST_DONE && out_free) begin
			result_q <= {{(ACC_W - ROOT_W){1'b0}}, root_q};
			ovf_q <= sqrt_ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result_value = result_q;
	assign overflow = ovf_q;

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_RUN |-> !pop)
		else $error("term taken while the root unit is busy");

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQRT |-> acc_q == '0 && !sat_q)
		else $error("accumulator not cleared after last component");

	a_sqrt_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQRT && cnt_q == SCNT_W'(SQRT_STEPS - 1) |=> state_q == ST_DONE)
		else $error("root unit ran past its step count");

endmodule
`default_nettype wire
